/* hdl/ewh_pkg.sv */
`timescale 1ns / 1ps

package ewh_pkg;

  // Fixed field widths of the ports.
  localparam int SAMPLE_W  = 32;
  localparam int COUNT_W   = 11;
  localparam int CFG_W     = 7;

  // Largest bin count before it saturates, and the reset bin setting.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;
  localparam logic [CFG_W-1:0]   CFG_RESET = 7'd10;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_LOAD,
    S_RD,
    S_MUL,
    S_DIVST,
    S_DIVW,
    S_BRD,
    S_BWR,
    S_SCAN,
    S_SCANEND,
    S_EMIT,
    S_OUT
  } state_t;

endpackage

/* hdl/ewh_div.sv */
`timescale 1ns / 1ps

// Restoring divider that produces one quotient bit per cycle. The caller
// guarantees that the quotient fits in Q_W bits.
module ewh_div #(
  parameter int NUM_W = 39,
  parameter int DEN_W = 32,
  parameter int Q_W   = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quo
);

  localparam int SW = (Q_W > 1) ? $clog2(Q_W) : 1;

  logic [NUM_W-1:0] rem_r;
  logic [NUM_W-1:0] rem_nxt;
  logic [Q_W-1:0]   quo_r;
  logic [Q_W-1:0]   quo_nxt;
  logic [SW-1:0]    step_r;
  logic             busy_r;
  logic             done_r;
  logic [NUM_W-1:0] trial;

  // Shifted divisor for the current quotient bit.
  assign trial = NUM_W'(den) << step_r;

  // One trial subtraction.
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (rem_r >= trial) begin
      rem_nxt = rem_r - trial;
      quo_nxt = quo_r | (Q_W'(1) << step_r);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= SW'(Q_W - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  // Remainder and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* hdl/equal_width_histogram_sorted.sv */
`timescale 1ns / 1ps

// Equal-width histogram with sorted counts. Samples load at one request per
// cycle into a sample memory while the minimum and maximum are tracked; the
// request marked last starts the final pass, during which no request is
// taken. Each stored sample then costs a memory read, a 32 x KW multiply,
// a one-bit-per-cycle divide by the span (skipped when the span is zero)
// and a read-modify-write of the bin count memory. The counts are then
// sorted by selection, one full scan of the bin memory per result, plus
// the output handshake; the set then clears and loading resumes. Samples
// beyond MAX_SAMPLES are dropped, counts saturate at 2047, and a bin
// setting of 0 or above MAX_BINS acts as 1 or MAX_BINS.
module equal_width_histogram_sorted #(
  parameter int MAX_SAMPLES = 1024,
  parameter int MAX_BINS    = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [ewh_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [ewh_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic                              in_last_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ewh_pkg::COUNT_W-1:0]       out_bin_total,
  output logic                              out_last_bin
);

  localparam int SW   = ewh_pkg::SAMPLE_W;
  localparam int CW   = ewh_pkg::COUNT_W;
  localparam int TW   = $clog2(MAX_SAMPLES + 1);
  localparam int SAW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int KW   = $clog2(MAX_BINS + 1);
  localparam int BAW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int PW   = SW + KW;

  ewh_pkg::state_t state_r, state_nxt;

  logic [ewh_pkg::CFG_W-1:0] bins_in_use_r;
  logic [TW-1:0]             total_r;
  logic signed [SW-1:0]      min_r;
  logic signed [SW-1:0]      max_r;
  logic [KW-1:0]             k_r;
  logic [KW-1:0]             k_nxt;
  logic [TW-1:0]             idx_r;
  logic [PW-1:0]             prod_r;
  logic [SW-1:0]             span_r;
  logic [KW-1:0]             bin_r;
  logic [MAX_BINS-1:0]       bvld_r;
  logic [MAX_BINS-1:0]       used_r;
  logic [KW-1:0]             scan_r;
  logic [KW-1:0]             pos_r;
  logic                      rd_vld_r;
  logic [KW-1:0]             rd_idx_r;
  logic                      found_r;
  logic [CW-1:0]             best_r;
  logic [KW-1:0]             best_idx_r;
  logic                      out_valid_r;
  logic [CW-1:0]             out_total_r;
  logic                      out_last_r;

  logic signed [SW-1:0] smem_r [MAX_SAMPLES];
  logic signed [SW-1:0] smem_rdata_r;
  logic [CW-1:0]        bmem_r [MAX_BINS];
  logic [CW-1:0]        bmem_rdata_r;
  logic [BAW-1:0]       bmem_raddr;

  logic          in_take;
  logic          out_take;
  logic          store_full;
  logic [SW:0]   off_wide;
  logic [SW:0]   span_wide;
  logic [CW-1:0] cnt_cur;
  logic [CW-1:0] rd_val;
  logic          div_start;
  logic          div_done;
  logic [KW-1:0] div_quo;

  assign in_take    = in_valid && !in_stall;
  assign out_take   = out_valid_r && !out_stall;
  assign store_full = (total_r == TW'(MAX_SAMPLES));

  // Effective bin count from the register.
  always_comb begin
    if (bins_in_use_r == '0) begin
      k_nxt = KW'(1);
    end else if (bins_in_use_r > ewh_pkg::CFG_W'(MAX_BINS)) begin
      k_nxt = KW'(MAX_BINS);
    end else begin
      k_nxt = KW'(bins_in_use_r);
    end
  end

  // Offset and span from the minimum.
  assign off_wide  = {smem_rdata_r[SW-1], smem_rdata_r} - {min_r[SW-1], min_r};
  assign span_wide = {max_r[SW-1], max_r} - {min_r[SW-1], min_r};

  // Current count of the bin being updated and of the entry being scanned.
  assign cnt_cur = bvld_r[bin_r[BAW-1:0]] ? bmem_rdata_r : '0;
  assign rd_val  = bvld_r[rd_idx_r[BAW-1:0]] ? bmem_rdata_r : '0;

  // Bin number of the current sample from the quotient.
  ewh_div #(
    .NUM_W (PW),
    .DEN_W (SW),
    .Q_W   (KW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r),
    .den   (span_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Next state and handshake outputs.
  always_comb begin
    state_nxt  = state_r;
    in_stall   = 1'b1;
    div_start  = 1'b0;
    bmem_raddr = bin_r[BAW-1:0];
    case (state_r)
      ewh_pkg::S_LOAD: begin
        in_stall = 1'b0;
        if (in_valid && in_last_sample) begin
          state_nxt = ewh_pkg::S_RD;
        end
      end
      ewh_pkg::S_RD: state_nxt = ewh_pkg::S_MUL;
      ewh_pkg::S_MUL: begin
        state_nxt = (span_wide == '0) ? ewh_pkg::S_BRD : ewh_pkg::S_DIVST;
      end
      ewh_pkg::S_DIVST: begin
        div_start = 1'b1;
        state_nxt = ewh_pkg::S_DIVW;
      end
      ewh_pkg::S_DIVW: begin
        if (div_done) begin
          state_nxt = ewh_pkg::S_BRD;
        end
      end
      ewh_pkg::S_BRD: state_nxt = ewh_pkg::S_BWR;
      ewh_pkg::S_BWR: begin
        state_nxt = (idx_r + 1'b1 == total_r) ? ewh_pkg::S_SCAN : ewh_pkg::S_RD;
      end
      ewh_pkg::S_SCAN: begin
        bmem_raddr = scan_r[BAW-1:0];
        if (scan_r == k_r - 1'b1) begin
          state_nxt = ewh_pkg::S_SCANEND;
        end
      end
      ewh_pkg::S_SCANEND: state_nxt = ewh_pkg::S_EMIT;
      ewh_pkg::S_EMIT:    state_nxt = ewh_pkg::S_OUT;
      ewh_pkg::S_OUT: begin
        if (out_take) begin
          state_nxt = out_last_r ? ewh_pkg::S_LOAD : ewh_pkg::S_SCAN;
        end
      end
      default: state_nxt = ewh_pkg::S_LOAD;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ewh_pkg::S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_in_use_r <= ewh_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      bins_in_use_r <= cfg_wr_data;
    end
  end

  // Sample memory: written while loading, read during the binning pass.
  always_ff @(posedge clk) begin
    if (in_take && !store_full) begin
      smem_r[total_r[SAW-1:0]] <= in_sample_value;
    end
    smem_rdata_r <= smem_r[idx_r[SAW-1:0]];
  end

  // Bin count memory: read-modify-write per sample, then scanned.
  always_ff @(posedge clk) begin
    if (state_r == ewh_pkg::S_BWR) begin
      bmem_r[bin_r[BAW-1:0]] <= (cnt_cur == ewh_pkg::COUNT_MAX) ? cnt_cur
                                : cnt_cur + 1'b1;
    end
    bmem_rdata_r <= bmem_r[bmem_raddr];
  end

  // Set control: sample count, extremes, bin valid and used bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      min_r   <= '0;
      max_r   <= '0;
      bvld_r  <= '0;
      used_r  <= '0;
      idx_r   <= '0;
      k_r     <= '0;
      found_r <= 1'b0;
      scan_r  <= '0;
      pos_r   <= '0;
      rd_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= 1'b0;
      case (state_r)
        ewh_pkg::S_LOAD: begin
          if (in_take) begin
            if (!store_full) begin
              total_r <= total_r + 1'b1;
              if (total_r == '0) begin
                min_r <= in_sample_value;
                max_r <= in_sample_value;
              end else if (in_sample_value < min_r) begin
                min_r <= in_sample_value;
              end else if (in_sample_value > max_r) begin
                max_r <= in_sample_value;
              end
            end
            if (in_last_sample) begin
              k_r    <= k_nxt;
              idx_r  <= '0;
              bvld_r <= '0;
              used_r <= '0;
            end
          end
        end
        ewh_pkg::S_BWR: begin
          bvld_r[bin_r[BAW-1:0]] <= 1'b1;
          idx_r   <= idx_r + 1'b1;
          scan_r  <= '0;
          pos_r   <= '0;
          found_r <= 1'b0;
        end
        ewh_pkg::S_SCAN: begin
          rd_vld_r <= 1'b1;
          scan_r   <= scan_r + 1'b1;
        end
        ewh_pkg::S_EMIT: begin
          used_r[best_idx_r[BAW-1:0]] <= 1'b1;
          out_valid_r <= 1'b1;
        end
        ewh_pkg::S_OUT: begin
          if (out_take) begin
            out_valid_r <= 1'b0;
            scan_r      <= '0;
            found_r     <= 1'b0;
            pos_r       <= pos_r + 1'b1;
            if (out_last_r) begin
              total_r <= '0;
              min_r   <= '0;
              max_r   <= '0;
            end
          end
        end
        default: ;
      endcase
      // Selection compare on the scan read data; strict less keeps the first.
      if (rd_vld_r && !used_r[rd_idx_r[BAW-1:0]] && (!found_r || rd_val < best_r)) begin
        found_r <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rd_idx_r <= scan_r;
    if (state_r == ewh_pkg::S_MUL) begin
      prod_r <= PW'(off_wide[SW-1:0]) * PW'(k_r);
      span_r <= span_wide[SW-1:0];
      bin_r  <= k_r - 1'b1;
    end
    if (state_r == ewh_pkg::S_DIVW && div_done) begin
      bin_r <= (div_quo >= k_r) ? k_r - 1'b1 : div_quo;
    end
    if (rd_vld_r && !used_r[rd_idx_r[BAW-1:0]] && (!found_r || rd_val < best_r)) begin
      best_r     <= rd_val;
      best_idx_r <= rd_idx_r;
    end
    if (state_r == ewh_pkg::S_EMIT) begin
      out_total_r <= best_r;
      out_last_r  <= (pos_r == k_r - 1'b1);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bin_total = out_total_r;
  assign out_last_bin  = out_last_r;

  // A result is shown only while the sequencer waits for it to be taken.
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ewh_pkg::S_OUT))
    else $error("result valid outside output state");

  // The divider finishes only while the sequencer waits on it.
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ewh_pkg::S_DIVW))
    else $error("divider done while not waited on");

  // The sample count never exceeds the store depth.
  a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TW'(MAX_SAMPLES))
    else $error("sample count beyond store depth");

  // Delivering the final count clears the set.
  a_set_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && out_last_r) |=> (total_r == '0 && state_r == ewh_pkg::S_LOAD))
    else $error("set not cleared after final count");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_SAMPLES = 1024;
  localparam int MAX_BINS    = 64;
  localparam int HOLD_LEN    = 3000;

  // One directed request: sample, last flag, and a bin setting applied before it
  // when cfg_now is set. A typed-in expectation gives one count's index and value.
  typedef struct {
    logic signed [ewh_pkg::SAMPLE_W-1:0] sample;
    logic                                last;
    logic                                cfg_now;
    logic [ewh_pkg::CFG_W-1:0]           cfg_val;
    int                                  typed_n;
    int                                  typed_v;
  } hist_row_t;

  typedef struct {
    logic [ewh_pkg::COUNT_W-1:0] total;
    logic                        last;
  } count_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [ewh_pkg::CFG_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [ewh_pkg::SAMPLE_W-1:0] in_sample_value = '0;
  logic in_last_sample = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ewh_pkg::COUNT_W-1:0] out_bin_total;
  logic out_last_bin;

  // Idle percentages for the sender and the receiver, and a long hold-off.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  bit hold_toggle = 1'b0;
  bit hold_seen = 1'b0;
  int errors = 0;

  // Predictor state.
  logic signed [ewh_pkg::SAMPLE_W-1:0] set_samples[MAX_SAMPLES];
  int set_size = 0;
  logic signed [ewh_pkg::SAMPLE_W-1:0] set_min = '0, set_max = '0;
  logic [ewh_pkg::CFG_W-1:0] bin_setting = ewh_pkg::CFG_RESET;
  count_t pending_counts[$];

  equal_width_histogram_sorted DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample_value(in_sample_value), .in_last_sample(in_last_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_bin_total(out_bin_total), .out_last_bin(out_last_bin)
  );

  always #5 clk = ~clk;

  initial begin
    #80_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Take one sample into the predicted set; on the last flag, bin, sort and queue.
  task automatic predict_histogram(input logic signed [ewh_pkg::SAMPLE_W-1:0] x,
                                   input logic lst);
    int k;
    int counts[MAX_BINS];
    longint span, off;
    int b, v, j;
    if (set_size < MAX_SAMPLES) begin
      if (set_size == 0) begin
        set_min = x;
        set_max = x;
      end else if (x < set_min) begin
        set_min = x;
      end else if (x > set_max) begin
        set_max = x;
      end
      set_samples[set_size] = x;
      set_size++;
    end
    if (!lst) return;
    k = (bin_setting == 0) ? 1 : (bin_setting > MAX_BINS) ? MAX_BINS : int'(bin_setting);
    foreach (counts[i]) counts[i] = 0;
    span = longint'(set_max) - longint'(set_min);
    for (int i = 0; i < set_size; i++) begin
      if (span == 0) begin
        b = k - 1;
      end else begin
        off = longint'(set_samples[i]) - longint'(set_min);
        b = int'((off * k) / span);
        if (b >= k) b = k - 1;
      end
      if (counts[b] < ewh_pkg::COUNT_MAX) counts[b]++;
    end
    // Ascending insertion sort of the used bins.
    for (int i = 1; i < k; i++) begin
      v = counts[i];
      j = i;
      while (j > 0 && counts[j-1] > v) begin
        counts[j] = counts[j-1];
        j--;
      end
      counts[j] = v;
    end
    for (int i = 0; i < k; i++) begin
      pending_counts.push_back('{ewh_pkg::COUNT_W'(counts[i]), i == k - 1});
    end
    set_size = 0;
    set_min = '0;
    set_max = '0;
  endtask

  // Offer one request and hold it until accepted, with random sender gaps.
  task automatic send_sample(input logic signed [ewh_pkg::SAMPLE_W-1:0] x,
                             input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_value <= x;
    in_last_sample <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_histogram(x, lst);
  endtask

  // Wait until every expected count has arrived and the block has settled.
  task automatic drain_and_settle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_counts.size() != 0 && guard < 3_000_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
  endtask

  task automatic write_bins(input logic [ewh_pkg::CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bin_setting = val;
  endtask

  // Receiver: random stalls plus a long hold-off started by a toggle.
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_cycles <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each accepted count with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_counts.size() == 0) begin
        $error("unexpected count %0d", out_bin_total);
        errors++;
      end else begin
        count_t e;
        e = pending_counts.pop_front();
        if (out_bin_total !== e.total) begin
          $error("bin_total expected %0d actual %0d", e.total, out_bin_total);
          errors++;
        end
        if (out_last_bin !== e.last) begin
          $error("last_bin expected %0d actual %0d", e.last, out_last_bin);
          errors++;
        end
      end
    end
  end

  hist_row_t directed[] = '{
    // After reset: one sample, reset setting of 10 bins, all in the last bin.
    '{32'sd5, 1'b1, 1'b0, 7'd0, 10, 1},
    // Extremes of the sample range, one bin setting of zero (acts as one bin).
    '{-32'sd2147483648, 1'b0, 1'b1, 7'd0, 0, 0},
    '{32'sd2147483647, 1'b0, 1'b0, 7'd0, 0, 0},
    '{32'sd0, 1'b1, 1'b0, 7'd0, 1, 3},
    // Above the bin limit acts as 64 bins.
    '{32'sd100, 1'b0, 1'b1, 7'd127, 0, 0},
    '{-32'sd100, 1'b0, 1'b0, 7'd0, 0, 0},
    '{32'sd99, 1'b0, 1'b0, 7'd0, 0, 0},
    '{32'sd0, 1'b1, 1'b0, 7'd0, 0, 0},
    // All samples equal.
    '{32'sd7, 1'b0, 1'b1, 7'd4, 0, 0},
    '{32'sd7, 1'b0, 1'b0, 7'd0, 0, 0},
    '{32'sd7, 1'b1, 1'b0, 7'd0, 0, 0},
    // Full 64 bins, spread of samples including sign bits.
    '{32'sh5555AAAA, 1'b0, 1'b1, 7'd64, 0, 0},
    '{32'shAAAA5555, 1'b0, 1'b0, 7'd0, 0, 0},
    '{32'sh00010000, 1'b0, 1'b0, 7'd0, 0, 0},
    '{32'shFFFF0000, 1'b1, 1'b0, 7'd0, 0, 0},
    // Two bins, sample at the maximum goes to the last bin.
    '{32'sd0, 1'b0, 1'b1, 7'd2, 0, 0},
    '{32'sd10, 1'b0, 1'b0, 7'd0, 0, 0},
    '{32'sd5, 1'b1, 1'b0, 7'd0, 0, 0}
  };

  initial begin
    int n, k, mode;
    logic signed [ewh_pkg::SAMPLE_W-1:0] base, x;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    foreach (directed[r]) begin
      if (directed[r].cfg_now) begin
        drain_and_settle();
        write_bins(directed[r].cfg_val);
      end
      send_sample(directed[r].sample, directed[r].last);
      if (directed[r].typed_n > 0 && pending_counts.size() >= directed[r].typed_n) begin
        if (pending_counts[directed[r].typed_n-1].total != directed[r].typed_v) begin
          $error("bin_total expected %0d actual %0d", directed[r].typed_v,
                 pending_counts[directed[r].typed_n-1].total);
          errors++;
        end
      end
    end
    drain_and_settle();

    // Random sets across idling phases; small sets, one long hold-off.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      drain_and_settle();
      k = (ph == 3) ? 64 : (ph == 5) ? 1 : $urandom_range(127);
      write_bins(k[ewh_pkg::CFG_W-1:0]);
      for (int s = 0; s < 6; s++) begin
        n = $urandom_range(1, 18);
        mode = $urandom_range(3);
        base = $urandom;
        if (ph == 2 && s == 0) hold_toggle = ~hold_toggle;
        for (int i = 0; i < n; i++) begin
          case (mode)
            0: x = $urandom;
            1: x = base + ewh_pkg::SAMPLE_W'($urandom_range(255));
            2: x = base;
            default: x = ewh_pkg::SAMPLE_W'($urandom_range(7)) - 32'sd3;
          endcase
          send_sample(x, i == n - 1);
        end
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_and_settle();

    if (errors == 0 && pending_counts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/ewh_pkg.sv
hdl/ewh_div.sv
hdl/equal_width_histogram_sorted.sv
sim/testbench.sv
